### sv/homogeneous_point_transform_core_defines.svh
// assertion macros for the homogeneous point transform core
// used by the top level; expects clk and rst in the including scope
`ifndef HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication
`define HPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/hpt_pkg.sv
// shared types and constants for the homogeneous point transform core
// no dependencies
`default_nettype none

package hpt_pkg;

  localparam int DATA_W = 32;
  localparam int EPS_W = 31;
  localparam int DIM = 4;
  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W = 4;
  localparam int QUO_W = 31;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  // one multiply-accumulate issue
  typedef struct packed {
    logic       mul_en;
    logic [1:0] row;
    logic [1:0] col;
  } mac_ctl_t;

  // divider lane control
  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

### sv/hpt_channels.sv
// valid/ready channel interfaces for the homogeneous point transform core
// depends on hpt_pkg
`default_nettype none

interface hpt_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [hpt_pkg::IDX_W-1:0]          entry_index;
  logic signed [hpt_pkg::DATA_W-1:0]  entry_value;
  logic signed [hpt_pkg::DATA_W-1:0]  point_x;
  logic signed [hpt_pkg::DATA_W-1:0]  point_y;
  logic signed [hpt_pkg::DATA_W-1:0]  point_z;

  modport source (output valid, action, entry_index, entry_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, action, entry_index, entry_value, point_x, point_y, point_z,
                output ready);
endinterface

interface hpt_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hpt_pkg::DATA_W-1:0]  out_x;
  logic signed [hpt_pkg::DATA_W-1:0]  out_y;
  logic signed [hpt_pkg::DATA_W-1:0]  out_z;
  logic                               w_degenerate;

  modport source (output valid, out_x, out_y, out_z, w_degenerate, input ready);
  modport sink (input valid, out_x, out_y, out_z, w_degenerate, output ready);
endinterface

interface hpt_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hpt_pkg::EPS_W-1:0]  w_epsilon;

  modport source (output valid, w_epsilon, input ready);
  modport sink (input valid, w_epsilon, output ready);
endinterface

`default_nettype wire

### sv/homogeneous_point_transform_core.sv
// Homogeneous 4x4 point transform with perspective divide. A load beat
// (action 0) writes one signed matrix entry and gives no
// result. A transform beat (action 1) extends the point with w = 1.0, runs
// the sixteen matrix products through one shared 32x32 multiplier (the w
// column multiplies by 1.0), then divides x, y and z by w in three
// restoring divider lanes that retire one quotient bit per cycle together.
// A transform passes from its accepted beat through the multiplier passes,
// a drain state, the w check, the divide steps and an output state before
// the next beat is accepted; the divide steps are skipped when w is below
// w_epsilon or zero, and the result then is the zero point with w_degenerate
// set. A previous result still waiting downstream stretches the output
// cycle. Quotients saturate to the 32-bit range. A finished result waits in
// the output register while the next beat enters.
// w_epsilon resets to 1 and may be written at any time the block is idle.
// Depends on hpt_pkg, hpt_channels, hpt_mac, hpt_div and the defines header.
`default_nettype none
`include "homogeneous_point_transform_core_defines.svh"

module homogeneous_point_transform_core #(
  parameter int FRAC_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  hpt_in_if.sink    pt_in,
  hpt_out_if.source pt_out,
  hpt_cfg_if.sink   cfg
);

  localparam int DW = hpt_pkg::DATA_W;
  localparam int ACC_W = 2*DW - FRAC_BITS + 2;
  localparam int DCNT_W = $clog2(hpt_pkg::QUO_W);
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(hpt_pkg::QUO_W - 1);
  localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_FLUSH = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [hpt_pkg::IDX_W-1:0] cnt;
  logic [DCNT_W-1:0]         dcnt;
  logic [hpt_pkg::EPS_W-1:0] w_eps;
  logic signed [DW-1:0]      mat [hpt_pkg::NUM_ENTRIES];
  logic signed [DW-1:0]      pt [3];
  logic                      degen;

  logic                    in_acc;
  logic                    out_free;
  logic                    w_bad;
  logic signed [DW-1:0]    mul_b;
  hpt_pkg::mac_ctl_t       mac_ctl;
  hpt_pkg::div_ctl_t       div_ctl;
  logic signed [ACC_W-1:0] comp [hpt_pkg::DIM];
  logic signed [DW-1:0]    quo [3];

  assign pt_in.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_acc = pt_in.valid && pt_in.ready;
  assign out_free = !pt_out.valid || pt_out.ready;

  assign w_bad = (comp[3] < $signed(ACC_W'(w_eps))) || (comp[3] == '0);

  assign mul_b = (cnt[1:0] == 2'd3) ? ONE : pt[cnt[1:0]];

  always_comb begin
    mac_ctl.mul_en = (state == S_MAC);
    mac_ctl.row    = cnt[3:2];
    mac_ctl.col    = cnt[1:0];
    div_ctl.load   = (state == S_CHECK) && !w_bad;
    div_ctl.step   = (state == S_DIV);
  end

  hpt_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (mat[cnt]),
    .b    (mul_b),
    .comp (comp)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    hpt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk    (clk),
      .ctl    (div_ctl),
      .num    (comp[g]),
      .w      (comp[3]),
      .result (quo[g])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && pt_in.action == hpt_pkg::ACT_XFORM) state_next = S_MAC;
      end
      S_MAC: begin
        if (cnt == '1) state_next = S_FLUSH;
      end
      S_FLUSH: state_next = S_CHECK;
      S_CHECK: state_next = w_bad ? S_DONE : S_DIV;
      S_DIV: begin
        if (dcnt == DCNT_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      w_eps        <= hpt_pkg::EPS_W'(1);
      pt_out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        w_eps <= cfg.w_epsilon;
      end
      if (state == S_DONE && out_free) begin
        pt_out.valid <= 1'b1;
      end else if (pt_out.ready) begin
        pt_out.valid <= 1'b0;
      end
    end
  end

  // matrix store, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hpt_pkg::NUM_ENTRIES; i++) begin
        mat[i] <= '0;
      end
    end else if (in_acc && pt_in.action == hpt_pkg::ACT_LOAD) begin
      mat[pt_in.entry_index] <= pt_in.entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pt[0] <= pt_in.point_x;
      pt[1] <= pt_in.point_y;
      pt[2] <= pt_in.point_z;
      cnt   <= '0;
    end else if (state == S_MAC) begin
      cnt <= cnt + 1'b1;
    end
    if (state == S_CHECK) begin
      degen <= w_bad;
      dcnt  <= '0;
    end else if (state == S_DIV) begin
      dcnt <= dcnt + 1'b1;
    end
    if (state == S_DONE && out_free) begin
      pt_out.out_x        <= degen ? '0 : quo[0];
      pt_out.out_y        <= degen ? '0 : quo[1];
      pt_out.out_z        <= degen ? '0 : quo[2];
      pt_out.w_degenerate <= degen;
    end
  end

  `HPT_ASSERT_NEXT(a_xform_starts,
    in_acc && pt_in.action == hpt_pkg::ACT_XFORM, state == S_MAC,
    "transform beat did not start the multiply pass")
  `HPT_ASSERT_NEXT(a_div_ends,
    state == S_DIV && dcnt == DCNT_LAST, state == S_DONE,
    "divide did not finish after the last quotient bit")
  `HPT_ASSERT_NOW(a_degen_zero,
    pt_out.valid && pt_out.w_degenerate,
    pt_out.out_x == '0 && pt_out.out_y == '0 && pt_out.out_z == '0,
    "degenerate result carries a nonzero point")

endmodule

`default_nettype wire

### sv/hpt_mac.sv
// shared multiply-accumulate unit: one 32x32 product per cycle, then rescale and add
// depends on hpt_pkg
`default_nettype none

module hpt_mac #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire hpt_pkg::mac_ctl_t                             ctl,
  input  wire logic signed [hpt_pkg::DATA_W-1:0]             a,
  input  wire logic signed [hpt_pkg::DATA_W-1:0]             b,
  output      logic signed [2*hpt_pkg::DATA_W-FRAC_BITS+1:0] comp [hpt_pkg::DIM]
);

  localparam int ACC_W = 2*hpt_pkg::DATA_W - FRAC_BITS + 2;

  logic signed [2*hpt_pkg::DATA_W-1:0] prod;
  logic                                add_vld;
  logic [1:0]                          add_row;
  logic [1:0]                          add_col;
  logic signed [ACC_W-1:0]             acc;
  logic signed [ACC_W-1:0]             scaled;
  logic signed [ACC_W-1:0]             sum;

  // floor rescale of the exact product
  assign scaled = ACC_W'(prod >>> FRAC_BITS);
  assign sum = ((add_col == 2'd0) ? '0 : acc) + scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_vld <= 1'b0;
    end else begin
      add_vld <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod    <= a * b;
      add_row <= ctl.row;
      add_col <= ctl.col;
    end
    if (add_vld) begin
      acc <= sum;
      if (add_col == 2'd3) begin
        comp[add_row] <= sum;
      end
    end
  end

endmodule

`default_nettype wire

### sv/hpt_div.sv
// one lane of the restoring divider: num * 2^FRAC_BITS / w, one quotient bit per step
// depends on hpt_pkg
`default_nettype none

module hpt_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                          clk,
  input  wire hpt_pkg::div_ctl_t                             ctl,
  input  wire logic signed [2*hpt_pkg::DATA_W-FRAC_BITS+1:0] num,
  input  wire logic signed [2*hpt_pkg::DATA_W-FRAC_BITS+1:0] w,
  output      logic signed [hpt_pkg::DATA_W-1:0]             result
);

  localparam int ACC_W = 2*hpt_pkg::DATA_W - FRAC_BITS + 2;
  localparam int QW = hpt_pkg::QUO_W;
  localparam int SH = QW - FRAC_BITS;
  localparam int CW = ACC_W + SH;

  logic             neg_in;
  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] w_u;
  logic             sat_in;
  logic [ACC_W-1:0] r2;
  logic             ge;

  logic             neg;
  logic             sat;
  logic [ACC_W-1:0] rem;
  logic [QW-1:0]    sh;
  logic [QW-1:0]    q;

  assign neg_in = num[ACC_W-1];
  assign mag = neg_in ? ACC_W'(-num) : ACC_W'(num);
  assign w_u = ACC_W'(w);
  // integer part of the quotient reaches 2^(31-FRAC_BITS)
  assign sat_in = CW'(mag) >= (CW'(w_u) << SH);
  // remainder stays below w, so its top bit is free for the shift
  assign r2 = {rem[ACC_W-2:0], sh[QW-1]};
  assign ge = r2 >= w_u;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= neg_in;
      sat <= sat_in;
      rem <= mag >> SH;
      sh  <= QW'({mag, {FRAC_BITS{1'b0}}});
      q   <= '0;
    end else if (ctl.step) begin
      rem <= ge ? (r2 - w_u) : r2;
      sh  <= {sh[QW-2:0], 1'b0};
      q   <= {q[QW-2:0], ge};
    end
  end

  always_comb begin
    if (sat) begin
      result = neg ? hpt_pkg::SAT_NEG : hpt_pkg::SAT_POS;
    end else if (neg) begin
      result = hpt_pkg::DATA_W'(0) - hpt_pkg::DATA_W'(q);
    end else begin
      result = hpt_pkg::DATA_W'(q);
    end
  end

endmodule

`default_nettype wire

### bench/homogeneous_point_transform_core_tb.sv
// testbench for homogeneous_point_transform_core: matrix loads, point transforms, w_epsilon phases
// depends on hpt_pkg, the hpt_channels interfaces and the core itself
`timescale 1ns / 100ps

module homogeneous_point_transform_core_tb;

  localparam int DATA_W = hpt_pkg::DATA_W;
  localparam int IDX_W = hpt_pkg::IDX_W;
  localparam int EPS_W = hpt_pkg::EPS_W;
  localparam int NUM_ENTRIES = hpt_pkg::NUM_ENTRIES;
  localparam int DIM = hpt_pkg::DIM;

  localparam int FRAC = 16;
  localparam int CLK_PERIOD = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PER_PHASE = 180;
  localparam int NUM_PHASES = 5;

  localparam logic signed [DATA_W-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] MAX_Q = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_Q = 32'sh8000_0000;

  typedef struct packed {
    logic                     action;
    logic [IDX_W-1:0]         entry_index;
    logic signed [DATA_W-1:0] entry_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } hpt_in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic                     w_degenerate;
  } hpt_out_beat_t;

  class point_scoreboard;
    logic signed [DATA_W-1:0] matrix [NUM_ENTRIES];
    logic [EPS_W-1:0] w_eps;
    hpt_out_beat_t expected_points [$];
    int mismatches;

    function new();
      foreach (matrix[i]) matrix[i] = '0;
      w_eps = 1;
      mismatches = 0;
    endfunction

    function void set_epsilon(logic [EPS_W-1:0] v);
      w_eps = v;
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    // num * 2^FRAC / w, w positive, truncated toward zero, saturated
    function logic [DATA_W-1:0] divide_by_w(longint num, longint w);
      logic [95:0] mag;
      logic [95:0] quo;
      logic neg;
      neg = (num < 0);
      mag = neg ? 96'(-num) : 96'(num);
      quo = (mag << FRAC) / 96'(w);
      if (quo >= (96'd1 << (DATA_W - 1)))
        return neg ? hpt_pkg::SAT_NEG : hpt_pkg::SAT_POS;
      return neg ? (32'd0 - quo[DATA_W-1:0]) : quo[DATA_W-1:0];
    endfunction

    function hpt_out_beat_t project_point(hpt_in_beat_t b);
      longint coord [3];
      longint acc [DIM];
      longint eps_l;
      hpt_out_beat_t res;
      coord[0] = longint'($signed(b.point_x));
      coord[1] = longint'($signed(b.point_y));
      coord[2] = longint'($signed(b.point_z));
      for (int r = 0; r < DIM; r++) begin
        // w = 1.0 column enters unscaled, products round toward minus infinity
        acc[r] = longint'($signed(matrix[r*DIM+3]));
        for (int k = 0; k < 3; k++)
          acc[r] += (longint'($signed(matrix[r*DIM+k])) * coord[k]) >>> FRAC;
      end
      eps_l = longint'({1'b0, w_eps});
      if (acc[3] < eps_l || acc[3] == 0) begin
        res.out_x = '0;
        res.out_y = '0;
        res.out_z = '0;
        res.w_degenerate = 1'b1;
      end else begin
        res.out_x = divide_by_w(acc[0], acc[3]);
        res.out_y = divide_by_w(acc[1], acc[3]);
        res.out_z = divide_by_w(acc[2], acc[3]);
        res.w_degenerate = 1'b0;
      end
      return res;
    endfunction

    function void note_input(hpt_in_beat_t b);
      if (b.action == hpt_pkg::ACT_LOAD)
        matrix[b.entry_index] = b.entry_value;
      else
        expected_points.push_back(project_point(b));
    endfunction

    function void check_result(hpt_out_beat_t got);
      hpt_out_beat_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: result beat with nothing expected x=%h y=%h z=%h degen=%b",
                   $time, got.out_x, got.out_y, got.out_z, got.w_degenerate);
        return;
      end
      want = expected_points.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.w_degenerate !== want.w_degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: expected x=%h y=%h z=%h degen=%b, got x=%h y=%h z=%h degen=%b",
                   $time, want.out_x, want.out_y, want.out_z, want.w_degenerate,
                   got.out_x, got.out_y, got.out_z, got.w_degenerate);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit calm;
  int sent_count;
  int cycle_count;
  point_scoreboard sb = new();

  hpt_in_if  pt_in_bus ();
  hpt_out_if pt_out_bus ();
  hpt_cfg_if cfg_bus ();

  homogeneous_point_transform_core #(.FRAC_BITS(FRAC)) dut (
    .clk   (clk),
    .rst   (rst),
    .pt_in (pt_in_bus),
    .pt_out(pt_out_bus),
    .cfg   (cfg_bus)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] rnd_q(int bits);
    logic [DATA_W-1:0] span;
    span = (32'd1 << (bits + 1)) - 32'd1;
    return $signed($urandom_range(0, span) - (32'd1 << bits));
  endfunction

  function automatic logic signed [DATA_W-1:0] rnd_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return rnd_q(22);
    if (pick < 8) return rnd_q(28);
    if (pick == 8) return $urandom;
    case ($urandom_range(0, 4))
      0: return MAX_Q;
      1: return MIN_Q;
      2: return '0;
      3: return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic hpt_in_beat_t make_load(int idx, logic signed [DATA_W-1:0] val);
    hpt_in_beat_t b;
    b.action = hpt_pkg::ACT_LOAD;
    b.entry_index = IDX_W'(idx);
    b.entry_value = val;
    b.point_x = $urandom;
    b.point_y = $urandom;
    b.point_z = $urandom;
    return b;
  endfunction

  function automatic hpt_in_beat_t make_xform(logic signed [DATA_W-1:0] x,
                                              logic signed [DATA_W-1:0] y,
                                              logic signed [DATA_W-1:0] z);
    hpt_in_beat_t b;
    b.action = hpt_pkg::ACT_XFORM;
    b.entry_index = IDX_W'($urandom_range(0, 15));
    b.entry_value = $urandom;
    b.point_x = x;
    b.point_y = y;
    b.point_z = z;
    return b;
  endfunction

  // valid is only lowered on a gap, so back-to-back beats keep it high
  task automatic send_beat(hpt_in_beat_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pt_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_in_bus.valid <= 1'b1;
    pt_in_bus.action <= b.action;
    pt_in_bus.entry_index <= b.entry_index;
    pt_in_bus.entry_value <= b.entry_value;
    pt_in_bus.point_x <= b.point_x;
    pt_in_bus.point_y <= b.point_y;
    pt_in_bus.point_z <= b.point_z;
    do @(posedge clk); while (pt_in_bus.ready !== 1'b1);
    sb.note_input(b);
    sent_count++;
  endtask

  task automatic wait_drained();
    pt_in_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // a load may still be in flight after the last result
  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one matrix (full or partial reload) followed by a run of points, or a broken sequence of stray beats
  task automatic run_sequence();
    logic signed [DATA_W-1:0] m [NUM_ENTRIES];
    int order [NUM_ENTRIES];
    int kind;
    int n;
    int j;
    int tmp;
    kind = $urandom_range(0, 9);
    calm = ($urandom_range(0, 4) == 0);
    if (kind == 9) begin
      // broken sequence: stray beats with raw content
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0)
          send_beat(make_load($urandom_range(0, 15), $urandom));
        else
          send_beat(make_xform($urandom, $urandom, $urandom));
      end
      return;
    end
    foreach (m[i]) m[i] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) m[r*DIM+c] = (r == c) ? rnd_q(18) : rnd_q(15);
      m[r*DIM+3] = rnd_q(26);
    end
    m[15] = ONE;
    case (kind)
      3, 4: begin
        // perspective row
        m[12] = rnd_q(12);
        m[13] = rnd_q(12);
        m[14] = rnd_q(17);
        m[15] = $urandom_range(ONE / 4, 8 * ONE);
      end
      5: begin
        foreach (m[i]) m[i] = rnd_q(17);
        m[15] = $urandom_range(ONE, 4 * ONE);
      end
      6: begin
        foreach (m[i]) m[i] = $urandom;
      end
      7: begin
        for (int c = 12; c < 16; c++) m[c] = '0;
      end
      8: begin
        // w near the top of the range, close to the largest epsilon
        m[12] = rnd_q(8);
        m[13] = rnd_q(8);
        m[14] = rnd_q(8);
        m[15] = ($urandom_range(0, 1) == 0) ? MAX_Q : MAX_Q - $urandom_range(0, 32'h000F_FFFF);
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        j = $urandom_range(0, 15);
        send_beat(make_load(j, m[j]));
      end
    end else begin
      foreach (order[i]) order[i] = i;
      for (int i = NUM_ENTRIES - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
      foreach (order[i]) send_beat(make_load(order[i], m[order[i]]));
    end
    n = $urandom_range(2, 10);
    repeat (n) send_beat(make_xform(rnd_coord(), rnd_coord(), rnd_coord()));
  endtask

  initial begin
    pt_out_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      int stall;
      hpt_out_beat_t got;
      stall = pick_gap();
      if (stall > 0) begin
        pt_out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pt_out_bus.ready <= 1'b1;
      do @(posedge clk); while (pt_out_bus.valid !== 1'b1);
      got.out_x = pt_out_bus.out_x;
      got.out_y = pt_out_bus.out_y;
      got.out_z = pt_out_bus.out_z;
      got.w_degenerate = pt_out_bus.w_degenerate;
      sb.check_result(got);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [EPS_W-1:0] eps_steps [NUM_PHASES];
    int phase_start;
    bit paused;
    rst <= 1'b1;
    pt_in_bus.valid <= 1'b0;
    pt_in_bus.action <= hpt_pkg::ACT_LOAD;
    pt_in_bus.entry_index <= '0;
    pt_in_bus.entry_value <= '0;
    pt_in_bus.point_x <= '0;
    pt_in_bus.point_y <= '0;
    pt_in_bus.point_z <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.w_epsilon <= '0;
    calm = 1'b0;
    sent_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // all-zero matrix after reset: w is zero
    send_beat(make_xform(ONE, 2 * ONE, 3 * ONE));
    send_beat(make_load(0, ONE));
    send_beat(make_load(5, ONE));
    send_beat(make_load(10, ONE));
    send_beat(make_load(15, ONE));
    send_beat(make_xform(32'sh0001_8000, -32'sh0002_4000, 3 * ONE));
    send_beat(make_xform(MAX_Q, MIN_Q, '0));
    // w = 0.5 drives both signs into saturation
    send_beat(make_load(15, 32'sh0000_8000));
    send_beat(make_xform(MAX_Q, MIN_Q, 32'sd1));
    send_beat(make_load(3, MAX_Q));
    send_beat(make_load(15, ONE));
    send_beat(make_xform(-32'sd1, '0, '0));
    // negative w
    send_beat(make_load(15, MIN_Q));
    send_beat(make_xform(ONE, ONE, ONE));
    // w equal to epsilon is not degenerate
    send_beat(make_load(15, 32'sd1));
    send_beat(make_xform(ONE, '0, '0));
    send_beat(make_load(12, MIN_Q));
    send_beat(make_load(15, '0));
    send_beat(make_xform(-ONE, MAX_Q, MIN_Q));

    eps_steps[0] = '0;
    eps_steps[1] = 31'h0001_0000;
    eps_steps[2] = 31'h7FFF_FFFF;
    eps_steps[3] = EPS_W'($urandom_range(2, 32'h0010_0000));
    eps_steps[4] = 31'd1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      cfg_bus.valid <= 1'b1;
      cfg_bus.w_epsilon <= eps_steps[p];
      do @(posedge clk); while (cfg_bus.ready !== 1'b1);
      cfg_bus.valid <= 1'b0;
      sb.set_epsilon(eps_steps[p]);
      if (eps_steps[p] == '0) begin
        // zero epsilon: an exactly zero w still counts as degenerate
        for (int c = 12; c < 16; c++) send_beat(make_load(c, '0));
        send_beat(make_xform($urandom, $urandom, $urandom));
      end
      phase_start = sent_count;
      paused = 1'b0;
      while (sent_count - phase_start < PER_PHASE) begin
        run_sequence();
        if (!paused && sent_count - phase_start > PER_PHASE / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
